// ===== src/rv32i_execute_unit_defines.svh =====
// Assertion helpers shared by the execute unit files.
// Every check is sampled on the rising edge of clk and held off while rst_n is low.
`ifndef RV32I_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("execute unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define EU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("execute unit check failed");

`endif

// ===== src/rv32i_eu_pkg.sv =====
package rv32i_eu_pkg;

  typedef enum logic [3:0] {
    MODE_LUI    = 4'd0,
    MODE_AUIPC  = 4'd1,
    MODE_JAL    = 4'd2,
    MODE_JALR   = 4'd3,
    MODE_OP_IMM = 4'd4,
    MODE_OP     = 4'd5,
    MODE_LOAD   = 4'd6,
    MODE_STORE  = 4'd7,
    MODE_BRANCH = 4'd8,
    MODE_NOP    = 4'd9
  } mode_t;

  // funct3 codes of the ALU operations.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes of the branch compares.
  localparam logic [2:0] BR_BEQ  = 3'd0;
  localparam logic [2:0] BR_BNE  = 3'd1;
  localparam logic [2:0] BR_BLT  = 3'd4;
  localparam logic [2:0] BR_BGE  = 3'd5;
  localparam logic [2:0] BR_BLTU = 3'd6;
  localparam logic [2:0] BR_BGEU = 3'd7;

  localparam logic [31:0] LINK_STEP  = 32'd4;
  localparam int          SHAMT_BITS = 5;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SLL,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_SRL,
    ALU_SRA,
    ALU_OR,
    ALU_AND
  } alu_op_t;

  // Control that rides along with an item through all stages.
  typedef struct packed {
    logic       jump;      // unconditional transfer
    logic       branch;    // conditional transfer
    logic [2:0] br_f3;     // branch compare code
    logic       res_zero;  // result field is forced to zero
    logic       tgt_en;    // target field carries the adder sum
    logic       tgt_clr0;  // clear bit 0 of the target
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    alu_op_t     alu_op;
    logic [31:0] alu_x;
    logic [31:0] alu_y;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
  } s1_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] alu_res;
    logic [31:0] tgt_sum;
    logic        eq;
    logic        lt;
    logic        ltu;
  } s2_t;

endpackage

// ===== src/rv32i_eu_dec.sv =====
module rv32i_eu_dec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         mode,
  input  logic [2:0]         funct3,
  input  logic               alt_bit,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic [31:0]        immediate,
  input  logic [31:0]        instr_addr,
  output logic               out_valid,
  input  logic               out_ready,
  output rv32i_eu_pkg::s1_t  out_data
);
  import rv32i_eu_pkg::*;

  logic valid_r;
  logic valid_nxt;
  s1_t  data_r;
  s1_t  data_nxt;
  logic load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // Operand steering: every class is mapped onto one ALU operation and one target add.
  always_comb begin
    data_nxt              = '0;
    data_nxt.alu_op       = ALU_ADD;
    data_nxt.alu_x        = operand_a;
    data_nxt.alu_y        = operand_b;
    data_nxt.tgt_x        = instr_addr;
    data_nxt.tgt_y        = immediate;
    data_nxt.ctl.br_f3    = funct3;
    case (mode)
      MODE_LUI: begin
        data_nxt.alu_x = '0;
        data_nxt.alu_y = immediate;
      end
      MODE_AUIPC: begin
        data_nxt.alu_x = instr_addr;
        data_nxt.alu_y = immediate;
      end
      MODE_JAL: begin
        data_nxt.alu_x      = instr_addr;
        data_nxt.alu_y      = LINK_STEP;
        data_nxt.ctl.jump   = 1'b1;
        data_nxt.ctl.tgt_en = 1'b1;
      end
      MODE_JALR: begin
        data_nxt.alu_x        = instr_addr;
        data_nxt.alu_y        = LINK_STEP;
        data_nxt.tgt_x        = operand_a;
        data_nxt.ctl.jump     = 1'b1;
        data_nxt.ctl.tgt_en   = 1'b1;
        data_nxt.ctl.tgt_clr0 = 1'b1;
      end
      MODE_OP_IMM, MODE_OP: begin
        if (mode == MODE_OP_IMM) begin
          data_nxt.alu_y = immediate;
        end
        case (funct3)
          F3_ADD:  data_nxt.alu_op = (mode == MODE_OP && alt_bit) ? ALU_SUB : ALU_ADD;
          F3_SLL:  data_nxt.alu_op = ALU_SLL;
          F3_SLT:  data_nxt.alu_op = ALU_SLT;
          F3_SLTU: data_nxt.alu_op = ALU_SLTU;
          F3_XOR:  data_nxt.alu_op = ALU_XOR;
          F3_SR:   data_nxt.alu_op = alt_bit ? ALU_SRA : ALU_SRL;
          F3_OR:   data_nxt.alu_op = ALU_OR;
          default: data_nxt.alu_op = ALU_AND;
        endcase
      end
      MODE_LOAD, MODE_STORE: begin
        data_nxt.alu_y = immediate;
      end
      MODE_BRANCH: begin
        data_nxt.ctl.branch   = 1'b1;
        data_nxt.ctl.res_zero = 1'b1;
        data_nxt.ctl.tgt_en   = 1'b1;
      end
      default: begin
        data_nxt.ctl.res_zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/rv32i_eu_alu.sv =====
module rv32i_eu_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rv32i_eu_pkg::s1_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rv32i_eu_pkg::s2_t  out_data
);
  import rv32i_eu_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  s2_t                   data_r;
  s2_t                   data_nxt;
  logic                  load;
  logic [SHAMT_BITS-1:0] shamt;
  logic                  lt;
  logic                  ltu;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  assign shamt = in_data.alu_y[SHAMT_BITS-1:0];
  assign lt    = $signed(in_data.alu_x) < $signed(in_data.alu_y);
  assign ltu   = in_data.alu_x < in_data.alu_y;

  always_comb begin
    data_nxt         = '0;
    data_nxt.ctl     = in_data.ctl;
    data_nxt.tgt_sum = in_data.tgt_x + in_data.tgt_y;
    data_nxt.eq      = in_data.alu_x == in_data.alu_y;
    data_nxt.lt      = lt;
    data_nxt.ltu     = ltu;
    case (in_data.alu_op)
      ALU_ADD:  data_nxt.alu_res = in_data.alu_x + in_data.alu_y;
      ALU_SUB:  data_nxt.alu_res = in_data.alu_x - in_data.alu_y;
      ALU_SLL:  data_nxt.alu_res = in_data.alu_x << shamt;
      ALU_SLT:  data_nxt.alu_res = {31'd0, lt};
      ALU_SLTU: data_nxt.alu_res = {31'd0, ltu};
      ALU_XOR:  data_nxt.alu_res = in_data.alu_x ^ in_data.alu_y;
      ALU_SRL:  data_nxt.alu_res = in_data.alu_x >> shamt;
      ALU_SRA:  data_nxt.alu_res = 32'($signed(in_data.alu_x) >>> shamt);
      ALU_OR:   data_nxt.alu_res = in_data.alu_x | in_data.alu_y;
      ALU_AND:  data_nxt.alu_res = in_data.alu_x & in_data.alu_y;
      default:  data_nxt.alu_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/rv32i_execute_unit.sv =====
// Channel   Direction  Ports                                   Contents
// in_       slave      in_tvalid/in_tready/in_tdata/in_tuser   one decoded instruction
// out_      master     out_tvalid/out_tready/out_tdata/out_tuser  one execute result
//
// Every item passes three register stages: operand steering, ALU and adders, and the
// branch decision with the output register. An accepted item is registered in the
// steering register, then the ALU register, then the output register with out_tvalid.
// One item is taken in every cycle while the output side keeps up.
// Each stage holds its item until the next stage can take it, so a stall on out_tready
// backs up stage by stage; up to three items are held and none is lost or repeated.
// Reset is synchronous on rst_n low; it clears only the stage valid bits and cnt_r.
`include "rv32i_execute_unit_defines.svh"

module rv32i_execute_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operand_a [31:0], operand_b [63:32], immediate [95:64], instr_addr [127:96]
  input  logic [127:0] in_tdata,
  // mode [3:0], funct3 [6:4], alt_bit [7]
  input  logic [7:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result [31:0], target_address [63:32]
  output logic [63:0]  out_tdata,
  // taken flag [0], redirect [1]
  output logic [1:0]   out_tuser
);
  import rv32i_eu_pkg::*;

  // Stage one: class decode and operand selection.
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  // Stage two: ALU result, target sum and compare flags.
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  // Stage three is the output register.
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_result_r;
  logic [31:0] out_result_nxt;
  logic [31:0] out_target_r;
  logic [31:0] out_target_nxt;
  logic        out_taken_r;
  logic        out_taken_nxt;
  ctl_t        out_ctl_r;
  logic        s3_load;

  // Items in flight, kept to cross-check the stage valid bits.
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] occ;
  logic       in_acc;
  logic       out_acc;

  rv32i_eu_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mode       (in_tuser[3:0]),
    .funct3     (in_tuser[6:4]),
    .alt_bit    (in_tuser[7]),
    .operand_a  (in_tdata[31:0]),
    .operand_b  (in_tdata[63:32]),
    .immediate  (in_tdata[95:64]),
    .instr_addr (in_tdata[127:96]),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  rv32i_eu_alu u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // The output register takes a new item when it is empty or its item leaves now.
  assign s2_ready      = !out_valid_r || out_tready;
  assign s3_load       = s2_valid && s2_ready;
  assign out_valid_nxt = s3_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Jumps are always taken; a branch follows its compare; unknown compares fall through.
  always_comb begin
    out_taken_nxt = 1'b0;
    if (s2_data.ctl.jump) begin
      out_taken_nxt = 1'b1;
    end else if (s2_data.ctl.branch) begin
      case (s2_data.ctl.br_f3)
        BR_BEQ:  out_taken_nxt = s2_data.eq;
        BR_BNE:  out_taken_nxt = !s2_data.eq;
        BR_BLT:  out_taken_nxt = s2_data.lt;
        BR_BGE:  out_taken_nxt = !s2_data.lt;
        BR_BLTU: out_taken_nxt = s2_data.ltu;
        BR_BGEU: out_taken_nxt = !s2_data.ltu;
        default: out_taken_nxt = 1'b0;
      endcase
    end
  end

  // Branches and no-ops report a zero result; non-control items report a zero target.
  // JALR drops bit zero of its computed target.
  always_comb begin
    out_result_nxt = s2_data.ctl.res_zero ? '0 : s2_data.alu_res;
    if (!s2_data.ctl.tgt_en) begin
      out_target_nxt = '0;
    end else if (s2_data.ctl.tgt_clr0) begin
      out_target_nxt = {s2_data.tgt_sum[31:1], 1'b0};
    end else begin
      out_target_nxt = s2_data.tgt_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_result_r <= out_result_nxt;
      out_target_r <= out_target_nxt;
      out_taken_r  <= out_taken_nxt;
      out_ctl_r    <= s2_data.ctl;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_target_r, out_result_r};
  // A taken transfer always redirects fetch.
  assign out_tuser  = {out_taken_r, out_taken_r};

  // Occupancy tracking for the checks below.
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  assign cnt_nxt = cnt_r + 2'(in_acc) - 2'(out_acc);
  assign occ     = 2'(s1_valid) + 2'(s2_valid) + 2'(out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // The stage valid bits account for exactly the items accepted and not yet delivered.
  `EU_ASSERT_IMP(a_occupancy, 1'b1, cnt_r == occ)
  // A result leaves the output register only through a completed handshake.
  `EU_ASSERT_IMP(a_no_drop, $fell(out_tvalid) && $past(rst_n), $past(out_tready))
  // A taken flag can come only from a jump or a branch.
  `EU_ASSERT_IMP(a_taken_ctl, out_tvalid && out_taken_r, out_ctl_r.jump || out_ctl_r.branch)
  // Items without a control transfer carry a zero target.
  `EU_ASSERT_IMP(a_tgt_zero, out_tvalid && !out_ctl_r.tgt_en, out_target_r == 32'd0)
  // A branch never writes back a value.
  `EU_ASSERT_IMP(a_br_res, out_tvalid && out_ctl_r.branch, out_result_r == 32'd0)

endmodule

// ===== tb/rv32i_execute_unit_test.sv =====
`timescale 1ns / 100ps

module rv32i_execute_unit_test;
  import rv32i_eu_pkg::*;

  // Give up after this many cycles past reset.
  localparam int CycleLimit = 200000;

  // The sender and the receiver both run without idling in this window, counted in
  // cycles after reset. This gives back-to-back traffic at the full rate.
  localparam int BusyStart = 200;
  localparam int BusyEnd   = 500;

  // The receiver holds out_tready low through this window while the sender keeps
  // offering items. The three stages fill up and in_tready must drop.
  localparam int HoldStart = 800;
  localparam int HoldEnd   = 1000;

  localparam int RandomOps = 850;

  // One decoded instruction as it enters the execute stage.
  typedef struct {
    mode_t       mode;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] pc;
  } exec_op_t;

  // What the execute stage hands on for one instruction.
  typedef struct {
    logic [31:0] result;
    logic        taken;
    logic        redirect;
    logic [31:0] target;
  } exec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All inputs of the block start at known values.
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;  // operand_a, operand_b, immediate, instr_addr
  logic [7:0]   in_tuser = '0;  // mode [3:0], funct3 [6:4], alt_bit [7]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;      // result [31:0], target_address [63:32]
  logic [1:0]   out_tuser;      // taken flag [0], redirect [1]

  exec_op_t  pending_ops[$];
  exec_res_t expected_results[$];

  // Set when the input item was accepted at the last rising edge. The driver reads it
  // at the falling edge to decide whether it may offer the next item.
  logic in_fire = 1'b0;
  int   tx_cycle = 0;
  int   rx_cycle = 0;
  int   run_cycles = 0;
  int   mismatch_count = 0;
  logic tx_idle;
  exec_op_t  tx_op;
  exec_op_t  rx_op;
  exec_res_t rx_want;
  exec_res_t rx_got;

  rv32i_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // ALU of the register and immediate forms. The shift amount is always the low five
  // bits of the second operand. Only the register form may subtract.
  function automatic logic [31:0] alu_eval(logic [31:0] x, logic [31:0] y, logic [2:0] f3,
                                           logic sub, logic arith);
    logic [4:0] sh;
    sh = y[SHAMT_BITS-1:0];
    case (f3)
      F3_ADD:  return sub ? x - y : x + y;
      F3_SLL:  return x << sh;
      F3_SLT:  return {31'd0, $signed(x) < $signed(y)};
      F3_SLTU: return {31'd0, x < y};
      F3_XOR:  return x ^ y;
      F3_SR: begin
        // Kept apart so that the arithmetic shift stays in a signed expression.
        if (arith) begin
          return $signed(x) >>> sh;
        end else begin
          return x >> sh;
        end
      end
      F3_OR:   return x | y;
      default: return x & y;
    endcase
  endfunction

  // Works out the result item of one instruction. Fields that a class does not set
  // stay zero, and a redirect is raised exactly when the transfer is taken.
  function automatic exec_res_t predict_execute(exec_op_t op);
    exec_res_t r;
    r = '{result: '0, taken: 1'b0, redirect: 1'b0, target: '0};
    case (op.mode)
      MODE_LUI:   r.result = op.imm;
      MODE_AUIPC: r.result = op.pc + op.imm;
      MODE_JAL: begin
        r.result = op.pc + LINK_STEP;
        r.taken  = 1'b1;
        r.target = op.pc + op.imm;
      end
      MODE_JALR: begin
        r.result = op.pc + LINK_STEP;
        r.taken  = 1'b1;
        r.target = (op.a + op.imm) & ~32'd1;
      end
      MODE_OP_IMM: r.result = alu_eval(op.a, op.imm, op.f3, 1'b0, op.alt);
      MODE_OP:     r.result = alu_eval(op.a, op.b, op.f3, op.alt, op.alt);
      MODE_LOAD, MODE_STORE: r.result = op.a + op.imm;
      MODE_BRANCH: begin
        // The target is reported whether or not the branch is taken. The two unused
        // compare codes are never taken.
        case (op.f3)
          BR_BEQ:  r.taken = op.a == op.b;
          BR_BNE:  r.taken = op.a != op.b;
          BR_BLT:  r.taken = $signed(op.a) < $signed(op.b);
          BR_BGE:  r.taken = $signed(op.a) >= $signed(op.b);
          BR_BLTU: r.taken = op.a < op.b;
          BR_BGEU: r.taken = op.a >= op.b;
          default: r.taken = 1'b0;
        endcase
        r.target = op.pc + op.imm;
      end
      default: ;
    endcase
    r.redirect = r.taken;
    return r;
  endfunction

  task automatic add_op(mode_t mode, logic [2:0] f3, logic alt, logic [31:0] a,
                        logic [31:0] b, logic [31:0] imm, logic [31:0] pc);
    pending_ops.insert(pending_ops.size(),
                       '{mode: mode, f3: f3, alt: alt, a: a, b: b, imm: imm, pc: pc});
  endtask

  // Half of the time a uniform word, else one of the values where compares, shifts and
  // carries change behavior.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0 + $urandom_range(0, 1);
      4: return 32'd0 + $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  // Driver: offers a new item when the line is free or the last item was just taken.
  always @(negedge clk) begin
    if (rst_n) begin
      tx_cycle <= tx_cycle + 1;
      if (!in_tvalid || in_fire) begin
        tx_idle = (tx_cycle < BusyStart || tx_cycle >= BusyEnd) &&
                  ($urandom_range(0, 99) < 33);
        if (!tx_idle && pending_ops.size() != 0) begin
          tx_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {tx_op.pc, tx_op.imm, tx_op.b, tx_op.a};
          in_tuser  <= {tx_op.alt, tx_op.f3, tx_op.mode};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, a stretch without any, and one long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HoldStart && rx_cycle < HoldEnd) begin
        out_tready <= 1'b0;
      end else if (rx_cycle >= BusyStart && rx_cycle < BusyEnd) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= $urandom_range(0, 99) >= 33;
      end
    end
  end

  // Monitor: each accepted input item adds its expected result, and each accepted
  // result item is checked against the oldest one still waiting.
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      run_cycles++;
      if (run_cycles > CycleLimit) begin
        $display("%0t: timeout with %0d items still to send and %0d results awaited",
                 $time, pending_ops.size(), expected_results.size());
        $display("tb: failure");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        rx_op.mode = mode_t'(in_tuser[3:0]);
        rx_op.f3   = in_tuser[6:4];
        rx_op.alt  = in_tuser[7];
        rx_op.a    = in_tdata[31:0];
        rx_op.b    = in_tdata[63:32];
        rx_op.imm  = in_tdata[95:64];
        rx_op.pc   = in_tdata[127:96];
        expected_results.insert(expected_results.size(), predict_execute(rx_op));
      end
      if (out_tvalid && out_tready) begin
        rx_got.result   = out_tdata[31:0];
        rx_got.target   = out_tdata[63:32];
        rx_got.taken    = out_tuser[0];
        rx_got.redirect = out_tuser[1];
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected, actual result %h target %h",
                   $time, rx_got.result, rx_got.target);
          mismatch_count++;
        end else begin
          rx_want = expected_results.pop_front();
          if (rx_got.result !== rx_want.result) begin
            $display("%0t: result expected %h actual %h", $time, rx_want.result,
                     rx_got.result);
            mismatch_count++;
          end
          if (rx_got.target !== rx_want.target) begin
            $display("%0t: target_address expected %h actual %h", $time, rx_want.target,
                     rx_got.target);
            mismatch_count++;
          end
          if (rx_got.taken !== rx_want.taken) begin
            $display("%0t: taken flag expected %b actual %b", $time, rx_want.taken,
                     rx_got.taken);
            mismatch_count++;
          end
          if (rx_got.redirect !== rx_want.redirect) begin
            $display("%0t: redirect expected %b actual %b", $time, rx_want.redirect,
                     rx_got.redirect);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    exec_op_t op;

    // Directed part. Upper immediate, PC-relative add and the jumps, with the link
    // address and the targets wrapping around the top of the address space. JALR
    // has an odd sum, so its low bit must be cleared.
    add_op(MODE_LUI, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0);
    add_op(MODE_AUIPC, 3'd0, 1'b0, 32'h0, 32'h0, 32'd8, 32'hFFFF_FFFC);
    add_op(MODE_JAL, 3'd0, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFC, 32'hFFFF_FFFC);
    add_op(MODE_JALR, 3'd0, 1'b0, 32'd1, 32'h0, 32'd2, 32'h0000_0100);

    // Immediate forms: ADDI must not subtract even with the alternate bit set. The
    // shift amount comes from the low five bits of the immediate only.
    add_op(MODE_OP_IMM, F3_ADD, 1'b1, 32'd5, 32'hFFFF_FFFF, 32'd3, 32'h0);
    add_op(MODE_OP_IMM, F3_SR, 1'b1, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_op(MODE_OP_IMM, F3_SR, 1'b0, 32'h8000_0000, 32'h0, 32'd31, 32'h0);
    add_op(MODE_OP_IMM, F3_SLL, 1'b1, 32'd1, 32'h0, 32'h0000_003F, 32'h0);
    add_op(MODE_OP_IMM, F3_SLT, 1'b0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    add_op(MODE_OP_IMM, F3_SLTU, 1'b0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);

    // Register forms: subtract through zero, add through the carry, an arithmetic
    // shift by zero, and the alternate bit on codes where it has no effect.
    add_op(MODE_OP, F3_ADD, 1'b1, 32'h0, 32'd1, 32'h0, 32'h0);
    add_op(MODE_OP, F3_ADD, 1'b0, 32'hFFFF_FFFF, 32'd1, 32'h0, 32'h0);
    add_op(MODE_OP, F3_SR, 1'b1, 32'h8000_0000, 32'h0000_0020, 32'h0, 32'h0);
    add_op(MODE_OP, F3_SLT, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
    add_op(MODE_OP, F3_XOR, 1'b1, 32'hA5A5_A5A5, 32'hFFFF_0000, 32'h0, 32'h0);
    add_op(MODE_OP, F3_OR, 1'b0, 32'hF0F0_0000, 32'h0000_0F0F, 32'h0, 32'h0);
    add_op(MODE_OP, F3_AND, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0);

    // Address generation for loads and stores.
    add_op(MODE_LOAD, 3'd2, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'd1, 32'h0);
    add_op(MODE_STORE, 3'd2, 1'b0, 32'h0, 32'hDEAD_BEEF, 32'h8000_0000, 32'h0);

    // Every branch compare code, including the two unused ones, with operands that are
    // ordered one way when signed and the other way when unsigned. The target wraps.
    for (int f = 0; f < 8; f++) begin
      add_op(MODE_BRANCH, 3'(f), 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h20, 32'hFFFF_FFF0);
    end

    // A no-op with every other field at its top value still yields an all-zero item.
    add_op(MODE_NOP, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random part. Branches see equal operands often enough to exercise both outcomes
    // of every compare.
    for (int n = 0; n < RandomOps; n++) begin
      op.mode = mode_t'(4'($urandom_range(0, 9)));
      op.f3   = 3'($urandom_range(0, 7));
      op.alt  = 1'($urandom_range(0, 1));
      op.a    = pick_word();
      op.b    = ($urandom_range(0, 3) == 0) ? op.a : pick_word();
      op.imm  = pick_word();
      op.pc   = pick_word();
      pending_ops.insert(pending_ops.size(), op);
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Wait until every item has gone in and every result has come back, then leave
    // time for any result that should not be there.
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (12) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rv32i_eu_pkg.sv
src/rv32i_eu_dec.sv
src/rv32i_eu_alu.sv
src/rv32i_execute_unit.sv
tb/rv32i_execute_unit_test.sv
